// ===== src/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg: shared types for the timer prescaler / period factor search
// Controller states and the command and status groups between control and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tpf_pkg;

	localparam int unsigned NW = 32; // target count width
	localparam int unsigned FW = 16; // factor width

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QMUL,
		ST_QREM,
		ST_QFIX,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_LOOP,
		ST_DIV_WAIT,
		ST_MUL,
		ST_CHK,
		ST_MUL2,
		ST_CMP,
		ST_FINISH
	} tpf_state_t;

	typedef struct packed {
		logic load_n;     // take the clamped target count
		logic div_start;  // launch the divider on n/a
		logic q_est;      // estimate (n-1)/FACTOR_MAX by reciprocal
		logic q_low;      // estimate times FACTOR_MAX
		logic set_a0;     // a = corrected quotient + 1
		logic set_b_init; // b = quotient, seed best pair and bound
		logic set_b;      // b = quotient
		logic mul;        // product = a*b
		logic bump;       // b = b + 1, 16-bit wrap
		logic take_best;  // keep current pair
		logic a_inc;      // advance a
		logic load_out;   // copy best pair to output register
	} tpf_cmd_t;

	typedef struct packed {
		logic div_done;
		logic a_last;     // a has reached FACTOR_MAX-1
		logic err_gt_half;
		logic better;
		logic exact;
	} tpf_sts_t;

endpackage

`default_nettype wire

// ===== src/tpf_div.sv =====
// ----------------------------------------------------------------------------
// tpf_div: iterative unsigned divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle; done pulses with the final bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_div
	import tpf_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [FW-1:0] divisor,
	output logic      [NW-1:0] quot,
	output logic               done
);

	logic [NW-1:0] quot_q;
	logic [FW-1:0] rem_q;
	logic [FW-1:0] div_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [FW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quot_q[NW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract where it fits
			quot_q <= {quot_q[NW-2:0], fits};
			rem_q  <= fits ? FW'(trial - {1'b0, div_q}) : trial[FW-1:0];
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== src/tpf_datapath.sv =====
// ----------------------------------------------------------------------------
// tpf_datapath: factor search datapath
// Holds target, candidate pair, best pair and error bound; one divider, one
// 16x16 multiplier for a*b, plus a reciprocal multiplier and a FACTOR_MAX
// multiplier for the starting prescaler, driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_datapath
	import tpf_pkg::*;
#(
	parameter int unsigned FACTOR_MAX = 65535
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [NW-1:0] target_count,
	input  wire tpf_cmd_t      cmd,
	output tpf_sts_t           sts,
	output logic      [FW-1:0] prescale_factor,
	output logic      [FW-1:0] period_factor
);

	localparam logic [63:0]   NMAX_W = 64'(FACTOR_MAX) * 64'(FACTOR_MAX);
	localparam logic [NW-1:0] NMAX   = NMAX_W[NW-1:0];
	localparam logic [FW-1:0] FMAX   = FW'(FACTOR_MAX);
	localparam logic [FW-1:0] A_END  = FW'(FACTOR_MAX - 1);
	// floor(2^32 / FACTOR_MAX): the estimate is the quotient or one below it
	localparam logic [NW-1:0] RECIP  = NW'((64'd1 << NW) / 64'(FACTOR_MAX));

	logic [NW-1:0] n_q;
	logic [NW-1:0] nm1_q;
	logic [FW-1:0] q_est_q;
	logic [NW-1:0] q_low_q;
	logic [FW-1:0] a_q;
	logic [FW-1:0] b_q;
	logic [NW-1:0] prod_q;
	logic [FW-1:0] best_a_q;
	logic [FW-1:0] best_b_q;
	logic [NW:0]   abs_best_q;
	logic [FW-1:0] out_a_q;
	logic [FW-1:0] out_b_q;

	logic [NW-1:0]   n_clamp;
	logic [NW-1:0]   nm1_clamp;
	logic [2*NW-1:0] recip_prod;
	logic [NW:0]     q_room;
	logic            q_fix;
	logic [NW-1:0]   quot;
	logic            div_done;
	logic [FW-1:0]   a_next0;
	logic [NW+1:0]   diff_pos;
	logic [NW+1:0]   diff_neg;
	logic [NW:0]     abs_err;

	always_comb begin
		if (target_count == '0) begin
			n_clamp   = NW'(1);
			nm1_clamp = '0;
		end else if (target_count > NMAX) begin
			n_clamp   = NMAX;
			nm1_clamp = NMAX - NW'(1);
		end else begin
			n_clamp   = target_count;
			nm1_clamp = target_count - NW'(1);
		end
	end

	tpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_q),
		.divisor  (a_q),
		.quot     (quot),
		.done     (div_done)
	);

	assign recip_prod = {{NW{1'b0}}, nm1_q} * {{NW{1'b0}}, RECIP};

	// bump the estimate where the remainder still holds a whole FACTOR_MAX
	assign q_room  = {1'b0, q_low_q} + {{(NW+1-FW){1'b0}}, FMAX};
	assign q_fix   = {1'b0, nm1_q} >= q_room;
	assign a_next0 = q_est_q + FW'(1) + {{(FW-1){1'b0}}, q_fix};

	assign diff_pos = {2'b00, prod_q} - {2'b00, n_q};
	assign diff_neg = {2'b00, n_q} - {2'b00, prod_q};
	assign abs_err  = diff_pos[NW+1] ? diff_neg[NW:0] : diff_pos[NW:0];

	assign sts.div_done    = div_done;
	assign sts.a_last      = a_q >= A_END;
	assign sts.err_gt_half = abs_err > {{(NW+1-FW+1){1'b0}}, a_q[FW-1:1]};
	assign sts.better      = abs_err < abs_best_q;
	assign sts.exact       = abs_err == '0;

	always_ff @(posedge clk) begin
		if (cmd.load_n) begin
			n_q   <= n_clamp;
			nm1_q <= nm1_clamp;
		end
		if (cmd.q_est)
			q_est_q <= recip_prod[NW+FW-1:NW];
		if (cmd.q_low)
			q_low_q <= {{(NW-FW){1'b0}}, q_est_q} * {{(NW-FW){1'b0}}, FMAX};
		if (cmd.set_a0)
			a_q <= (a_next0 == '0) ? FW'(1) : a_next0;
		else if (cmd.a_inc)
			a_q <= a_q + FW'(1);
		if (cmd.set_b_init || cmd.set_b)
			b_q <= quot[FW-1:0];
		else if (cmd.bump)
			b_q <= b_q + FW'(1);
		if (cmd.mul)
			prod_q <= {{(NW-FW){1'b0}}, a_q} * {{(NW-FW){1'b0}}, b_q};
		if (cmd.set_b_init) begin
			best_a_q   <= a_q;
			best_b_q   <= quot[FW-1:0];
			abs_best_q <= {1'b0, n_q};
		end else if (cmd.take_best) begin
			best_a_q   <= a_q;
			best_b_q   <= b_q;
			abs_best_q <= abs_err;
		end
		if (cmd.load_out) begin
			out_a_q <= best_a_q;
			out_b_q <= best_b_q;
		end
	end

	assign prescale_factor = out_a_q;
	assign period_factor   = out_b_q;

endmodule

`default_nettype wire

// ===== src/tpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpf_ctrl: factor search controller
// Sequences start-up steps, the walk over a, and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_ctrl
	import tpf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire tpf_sts_t sts,
	output tpf_cmd_t      cmd
);

	tpf_state_t state_q;
	tpf_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_QMUL;
			ST_QMUL:      state_d = ST_QREM;
			ST_QREM:      state_d = ST_QFIX;
			ST_QFIX:      state_d = ST_DIV1_GO;
			ST_DIV1_GO:   state_d = ST_DIV1_WAIT;
			ST_DIV1_WAIT: if (sts.div_done) state_d = ST_LOOP;
			ST_LOOP:      state_d = sts.a_last ? ST_FINISH : ST_DIV_WAIT;
			ST_DIV_WAIT:  if (sts.div_done) state_d = ST_MUL;
			ST_MUL:       state_d = ST_CHK;
			ST_CHK:       state_d = sts.err_gt_half ? ST_MUL2 : ST_CMP;
			ST_MUL2:      state_d = ST_CMP;
			ST_CMP:       state_d = (sts.better && sts.exact) ? ST_FINISH : ST_LOOP;
			ST_FINISH:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.load_n = in_valid;
			end
			ST_QMUL: begin
				cmd.q_est = 1'b1;
			end
			ST_QREM: begin
				cmd.q_low = 1'b1;
			end
			ST_QFIX: begin
				cmd.set_a0 = 1'b1;
			end
			ST_DIV1_GO: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV1_WAIT: begin
				cmd.set_b_init = sts.div_done;
			end
			ST_LOOP: begin
				cmd.div_start = !sts.a_last;
			end
			ST_DIV_WAIT: begin
				cmd.set_b = sts.div_done;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_CHK: begin
				cmd.bump = sts.err_gt_half;
			end
			ST_MUL2: begin
				cmd.mul = 1'b1;
			end
			ST_CMP: begin
				cmd.take_best = sts.better;
				// advance unless an exact match ends the walk
				cmd.a_inc     = !(sts.better && sts.exact);
			end
			ST_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/timer_prescaler_period_factoring_core.sv =====
// Search: up to 65533 steps over a, each waiting on the bit-serial divider; an exact
// match ends the walk early, and an empty walk goes straight to the result.
// Throughput: one word at a time; the next word is taken once the result is in the
// output register, which may still wait for the sink.
// Reset: arst_n clears the controller and output valid; data registers are not reset.
// ----------------------------------------------------------------------------
// timer_prescaler_period_factoring_core: prescaler / period factor search
// Finds 16-bit factors a and b whose product comes closest to a target count.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_prescaler_period_factoring_core
	import tpf_pkg::*;
#(
	parameter int unsigned FACTOR_MAX = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] target_count
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata   // [15:0] prescale_factor, [31:16] period_factor
);

	tpf_cmd_t      cmd;
	tpf_sts_t      sts;
	logic [FW-1:0] prescale_factor;
	logic [FW-1:0] period_factor;

	tpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpf_datapath #(
		.FACTOR_MAX (FACTOR_MAX)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.target_count    (s_axis_tdata),
		.cmd             (cmd),
		.sts             (sts),
		.prescale_factor (prescale_factor),
		.period_factor   (period_factor)
	);

	assign m_axis_tdata = {period_factor, prescale_factor};

endmodule

`default_nettype wire
